FILE: rtl/tgrd_pkg.sv
// shared types, constants and helper functions of the touch gamepad report decoder
// depends on nothing; front, queue, divider, back part and top level import it
package tgrd_pkg;

	localparam int IDX_W = 6;
	localparam int LEN_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;
	localparam int BTN_TABLE_SIZE = 10;
	localparam int TOUCH_LEN = 17;
	localparam int SWITCH_ID_LEN = 8;
	localparam int SWITCH_MIN_LEN = 7;
	localparam logic [7:0] SWITCH_ID_BYTE = 8'h01;
	localparam logic [7:0] ZR_MASK = 8'h80;
	localparam logic [7:0] ZL_MASK = 8'h40;
	localparam logic [8:0] TRAVEL_LX = 9'd300;
	localparam logic [8:0] TRAVEL_LY = 9'd240;
	localparam logic [8:0] TRAVEL_RX = 9'd145;
	localparam logic [8:0] TRAVEL_RY = 9'd120;
	localparam int QUO_W = 22;

	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd6;

	typedef struct packed {
		logic [7:0]       data;
		logic             wr;
		logic [IDX_W-1:0] idx;
		logic             last;
		logic [LEN_W-1:0] len;
	} queue_item_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic [14:0]        tup;
		logic [14:0]        tdown;
		logic [9:0]         mask;
		logic               kind;
	} result_t;

	typedef enum logic [3:0] {
		T_IDLE, T_SWID, T_SWCHK, T_FETCH, T_TIP, T_ZONE,
		T_DIVA, T_WAITA, T_DIVB, T_WAITB, T_DONE
	} back_state_t;

	function automatic logic [11:0] btn_x(input logic [3:0] j);
		case (j)
			4'd0: btn_x = 12'd332;
			4'd1: btn_x = 12'd780;
			4'd2: btn_x = 12'd241;
			4'd3: btn_x = 12'd818;
			4'd4: btn_x = 12'd723;
			4'd5: btn_x = 12'd352;
			4'd6: btn_x = 12'd534;
			4'd7: btn_x = 12'd536;
			4'd8: btn_x = 12'd1173;
			4'd9: btn_x = 12'd578;
			default: btn_x = 12'd0;
		endcase
	endfunction

	function automatic logic [11:0] btn_y(input logic [3:0] j);
		case (j)
			4'd0: btn_y = 12'd2044;
			4'd1: btn_y = 12'd1281;
			4'd2: btn_y = 12'd1270;
			4'd3: btn_y = 12'd2020;
			4'd4: btn_y = 12'd544;
			4'd5: btn_y = 12'd562;
			4'd6: btn_y = 12'd379;
			4'd7: btn_y = 12'd740;
			4'd8: btn_y = 12'd416;
			4'd9: btn_y = 12'd2041;
			default: btn_y = 12'd0;
		endcase
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [QUO_W-1:0] v);
		if (v > 22'sd32767) sat16 = 16'sh7fff;
		else if (v < -22'sd32768) sat16 = 16'sh8000;
		else sat16 = v[15:0];
	endfunction

	function automatic logic [14:0] clip15(input logic signed [QUO_W-1:0] v);
		if (v > 22'sd32767) clip15 = 15'h7fff;
		else clip15 = v[14:0];
	endfunction

endpackage

FILE: rtl/tgrd_if.sv
// channel interfaces of the decoder: report bytes in, decoded results out
// depends on nothing
interface tgrd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] report_byte;
	logic       last_byte;
	modport source(output valid, report_byte, last_byte, input ready);
	modport sink(input valid, report_byte, last_byte, output ready);
endinterface

interface tgrd_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll;
	logic signed [15:0] pitch;
	logic signed [15:0] yaw;
	logic [14:0]        throttle_up;
	logic [14:0]        throttle_down;
	logic [9:0]         button_mask;
	logic               report_kind;
	modport source(output valid, roll, pitch, yaw, throttle_up, throttle_down,
		button_mask, report_kind, input ready);
	modport sink(input valid, roll, pitch, yaw, throttle_up, throttle_down,
		button_mask, report_kind, output ready);
endinterface

FILE: rtl/tgrd_front.sv
// front part: accepts report bytes, keeps the byte count, tags each item
// depends on tgrd_pkg and tgrd_if
module tgrd_front #(
	parameter int MAX_REPORT_BYTES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tgrd_byte_if.sink            in_ch,
	output logic                 push_valid,
	input  logic                 push_ready,
	output tgrd_pkg::queue_item_t push_item
);
	import tgrd_pkg::*;

	localparam int CNTW = $clog2(MAX_REPORT_BYTES + 2);

	logic [CNTW-1:0] count_q;
	logic [CNTW-1:0] count_nx;

	assign in_ch.ready = push_ready;
	assign push_valid = in_ch.valid;

	// count saturates one past the maximum so long reports stay long
	assign count_nx = (count_q <= CNTW'(MAX_REPORT_BYTES)) ? count_q + CNTW'(1) : count_q;

	always_comb begin
		push_item.data = in_ch.report_byte;
		push_item.wr = count_q < CNTW'(MAX_REPORT_BYTES);
		push_item.idx = IDX_W'(count_q);
		push_item.last = in_ch.last_byte;
		push_item.len = LEN_W'(count_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_ch.valid && push_ready) begin
			count_q <= in_ch.last_byte ? '0 : count_nx;
		end
	end
endmodule

FILE: rtl/tgrd_queue.sv
// two-entry queue between the front and the back part
// depends on tgrd_pkg
module tgrd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  tgrd_pkg::queue_item_t push_item,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output tgrd_pkg::queue_item_t pop_item
);
	import tgrd_pkg::*;

	queue_item_t ent_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  fill_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = fill_q != 2'd2;
	assign pop_valid = fill_q != 2'd0;
	assign pop_item = ent_q[rptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) wptr_q <= ~wptr_q;
			if (do_pop) rptr_q <= ~rptr_q;
			if (do_push && !do_pop) fill_q <= fill_q + 2'd1;
			else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
		end
	end
endmodule

FILE: rtl/tgrd_div.sv
// reciprocal divider for the stick scaling, rounds to nearest away from zero
// depends on tgrd_pkg
module tgrd_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [12:0]                dist_in,
	input  logic [8:0]                        den,
	output logic                              done,
	output logic signed [tgrd_pkg::QUO_W-1:0] quo
);
	import tgrd_pkg::*;

	localparam int NUM_W = 27;
	localparam int RCP_W = 30;
	localparam int SH = 36;
	// ceil(2^36 / travel) gives the exact quotient for any numerator below 2^27
	localparam logic [RCP_W-1:0] RCP_LX =
		RCP_W'(((64'd1 << SH) + 64'(TRAVEL_LX) - 64'd1) / 64'(TRAVEL_LX));
	localparam logic [RCP_W-1:0] RCP_LY =
		RCP_W'(((64'd1 << SH) + 64'(TRAVEL_LY) - 64'd1) / 64'(TRAVEL_LY));
	localparam logic [RCP_W-1:0] RCP_RX =
		RCP_W'(((64'd1 << SH) + 64'(TRAVEL_RX) - 64'd1) / 64'(TRAVEL_RX));
	localparam logic [RCP_W-1:0] RCP_RY =
		RCP_W'(((64'd1 << SH) + 64'(TRAVEL_RY) - 64'd1) / 64'(TRAVEL_RY));

	logic [NUM_W-1:0]       num_q;
	logic [RCP_W-1:0]       rcp_q;
	logic [RCP_W-1:0]       rcp;
	logic [QUO_W-2:0]       quo_q;
	logic                   neg_q;
	logic                   busy_q;
	logic                   done_q;
	logic [11:0]            mag;
	logic [NUM_W+RCP_W-1:0] prod;

	assign mag = dist_in[12] ? 12'(-dist_in) : dist_in[11:0];
	assign prod = num_q * rcp_q;
	assign done = done_q;
	assign quo = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_comb begin
		unique case (den)
			TRAVEL_LX: rcp = RCP_LX;
			TRAVEL_LY: rcp = RCP_LY;
			TRAVEL_RX: rcp = RCP_RX;
			TRAVEL_RY: rcp = RCP_RY;
			default: rcp = '0;
		endcase
	end

	// numerator carries half the travel so the product rounds to nearest
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {mag, 15'd0} + NUM_W'(den >> 1);
			rcp_q <= rcp;
			neg_q <= dist_in[12];
		end
		if (busy_q) begin
			quo_q <= prod[SH+QUO_W-2:SH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end
endmodule

FILE: rtl/tgrd_back.sv
// back part: report buffer, decode sequencer, configuration and result register
// depends on tgrd_pkg and tgrd_div
module tgrd_back #(
	parameter int MAX_REPORT_BYTES = 32,
	parameter int NUM_CONTACTS = 4,
	parameter int NUM_BUTTON_ZONES = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pop_valid,
	output logic                              pop_ready,
	input  tgrd_pkg::queue_item_t             pop_item,
	input  logic                              cfg_we,
	input  logic [tgrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tgrd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                              res_valid,
	input  logic                              res_ready,
	output tgrd_pkg::result_t                 res
);
	import tgrd_pkg::*;

	localparam int AW = $clog2(MAX_REPORT_BYTES);
	localparam int NZ = (NUM_BUTTON_ZONES < BTN_TABLE_SIZE) ? NUM_BUTTON_ZONES : BTN_TABLE_SIZE;
	localparam int ZW = $clog2(NZ + 1);

	logic [7:0]  mem [MAX_REPORT_BYTES];
	logic [7:0]  rdata_q;
	logic [AW-1:0] rd_addr;

	logic [11:0] lcx_q, lcy_q, rcx_q, rcy_q, zone_q;
	logic [7:0]  tol_q;
	logic [14:0] db_q;

	back_state_t state_q, state_nx;
	logic        touch_q;
	logic        o_q;
	logic [1:0]  k_q;
	logic [2:0]  fc_q;
	logic [ZW-1:0] zi_q;
	logic [7:0]  bytes_q [4];
	logic        left_q;
	logic signed [15:0] roll_q, pitch_q, yaw_q;
	logic [14:0] tup_q, tdn_q;
	logic [9:0]  mask_q, kept_q;
	logic        res_valid_q;
	result_t     res_q;

	logic        pop;
	logic        last_k;
	logic [11:0] cx, cy;
	logic        tip, hit;
	logic signed [12:0] dx, dy, adx, ady;
	logic        div_start, div_done;
	logic signed [12:0] div_dist;
	logic [8:0]  div_den;
	logic signed [QUO_W-1:0] div_quo;
	logic signed [QUO_W-1:0] dbs;
	logic        out_free;
	logic [8:0]  pneg;
	logic [1:0]  swoff;

	assign pop = pop_valid && pop_ready;
	assign last_k = k_q == 2'(NUM_CONTACTS - 1);
	assign cx = {bytes_q[2][3:0], bytes_q[1]};
	assign cy = {bytes_q[3], bytes_q[2][7:4]};
	assign tip = bytes_q[0][0];
	assign dx = $signed({1'b0, cx}) - $signed({1'b0, btn_x(4'(zi_q))});
	assign dy = $signed({1'b0, cy}) - $signed({1'b0, btn_y(4'(zi_q))});
	assign adx = dx[12] ? -dx : dx;
	assign ady = dy[12] ? -dy : dy;
	assign hit = (adx <= $signed({5'd0, tol_q})) && (ady <= $signed({5'd0, tol_q}));
	assign out_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res = res_q;
	assign dbs = $signed({7'd0, db_q});

	// switch layout bytes: buttons, left x, left y, right x
	always_comb begin
		case (fc_q[1:0])
			2'd0: swoff = 2'd0;
			2'd1: swoff = 2'd3;
			2'd2: swoff = 2'd0;
			default: swoff = 2'd1;
		endcase
	end

	// divider operands: first pass gives throttle or roll, second yaw or pitch
	always_comb begin
		if (state_q == T_DIVA) begin
			div_dist = left_q ? $signed({1'b0, cx}) - $signed({1'b0, lcx_q})
				: $signed({1'b0, cy}) - $signed({1'b0, rcy_q});
			div_den = left_q ? TRAVEL_LX : TRAVEL_RY;
		end else begin
			div_dist = left_q ? $signed({1'b0, cy}) - $signed({1'b0, lcy_q})
				: $signed({1'b0, cx}) - $signed({1'b0, rcx_q});
			div_den = left_q ? TRAVEL_LY : TRAVEL_RX;
		end
	end

	tgrd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dist_in(div_dist),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (pop && pop_item.last) begin
					if (pop_item.len > LEN_W'(MAX_REPORT_BYTES)) state_nx = T_IDLE;
					else if (pop_item.len == LEN_W'(TOUCH_LEN)) state_nx = T_FETCH;
					else if (pop_item.len == LEN_W'(SWITCH_ID_LEN)) state_nx = T_SWID;
					else if (pop_item.len < LEN_W'(SWITCH_MIN_LEN)) state_nx = T_IDLE;
					else state_nx = T_FETCH;
				end
			end
			T_SWID: state_nx = T_SWCHK;
			T_SWCHK: state_nx = T_FETCH;
			T_FETCH: begin
				if (fc_q == 3'd4) state_nx = touch_q ? T_TIP : T_DONE;
			end
			T_TIP: begin
				if (tip) state_nx = T_ZONE;
				else state_nx = last_k ? T_DONE : T_FETCH;
			end
			T_ZONE: begin
				if (hit) state_nx = last_k ? T_DONE : T_FETCH;
				else if (zi_q == ZW'(NZ - 1)) state_nx = T_DIVA;
			end
			T_DIVA: state_nx = T_WAITA;
			T_WAITA: if (div_done) state_nx = T_DIVB;
			T_DIVB: state_nx = T_WAITB;
			T_WAITB: if (div_done) state_nx = last_k ? T_DONE : T_FETCH;
			T_DONE: if (out_free) state_nx = T_IDLE;
			default: state_nx = T_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop_ready = 1'b0;
		div_start = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			T_IDLE: pop_ready = 1'b1;
			T_FETCH: begin
				if (touch_q) rd_addr = AW'({k_q, fc_q[1:0]});
				else rd_addr = AW'({2'd0, fc_q[1], swoff} + {4'd0, o_q});
			end
			T_DIVA, T_DIVB: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && pop_item.wr) begin
			mem[AW'(pop_item.idx)] <= pop_item.data;
		end
		rdata_q <= mem[rd_addr];
	end

	assign pneg = 9'd128 - {1'b0, bytes_q[2]};

	always_ff @(posedge clk) begin
		unique case (state_q)
			T_IDLE: begin
				touch_q <= pop_item.len == LEN_W'(TOUCH_LEN);
				o_q <= 1'b0;
				k_q <= '0;
				fc_q <= '0;
				roll_q <= '0;
				pitch_q <= '0;
				yaw_q <= '0;
				tup_q <= '0;
				tdn_q <= '0;
				mask_q <= '0;
			end
			T_SWCHK: o_q <= rdata_q == SWITCH_ID_BYTE;
			T_FETCH: begin
				if (fc_q != 3'd0) bytes_q[2'(fc_q - 3'd1)] <= rdata_q;
				fc_q <= (fc_q == 3'd4) ? 3'd0 : fc_q + 3'd1;
			end
			T_TIP: begin
				zi_q <= '0;
				left_q <= cy < zone_q;
				if (!tip) k_q <= k_q + 2'd1;
			end
			T_ZONE: begin
				if (hit) begin
					mask_q <= mask_q | (10'd1 << zi_q);
					k_q <= k_q + 2'd1;
				end else begin
					zi_q <= zi_q + ZW'(1);
				end
			end
			T_WAITA: begin
				if (div_done) begin
					if (left_q) begin
						tup_q <= (div_quo > dbs) ? clip15(div_quo) : '0;
						tdn_q <= (div_quo < -dbs) ? clip15(-div_quo) : '0;
					end else begin
						roll_q <= sat16(div_quo);
					end
				end
			end
			T_WAITB: begin
				if (div_done) begin
					if (left_q) yaw_q <= sat16(div_quo);
					else pitch_q <= sat16(div_quo);
					k_q <= k_q + 2'd1;
				end
			end
			T_DONE: begin
				if (out_free) begin
					if (touch_q) begin
						res_q <= '{roll: roll_q, pitch: pitch_q, yaw: yaw_q, tup: tup_q,
							tdown: tdn_q, mask: mask_q, kind: 1'b0};
					end else begin
						res_q.roll <= {~bytes_q[1][7], bytes_q[1][6:0], 8'd0};
						res_q.pitch <= (bytes_q[2] == 8'd0) ? 16'sh7fff : {pneg[7:0], 8'd0};
						res_q.yaw <= {~bytes_q[3][7], bytes_q[3][6:0], 8'd0};
						res_q.tup <= ((bytes_q[0] & ZR_MASK) != 8'd0) ? 15'h7fff : 15'd0;
						res_q.tdown <= ((bytes_q[0] & ZL_MASK) != 8'd0) ? 15'h7fff : 15'd0;
						res_q.mask <= kept_q;
						res_q.kind <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			res_valid_q <= 1'b0;
			kept_q <= '0;
			lcx_q <= 12'd523;
			lcy_q <= 12'd500;
			rcx_q <= 12'd533;
			rcy_q <= 12'd1650;
			zone_q <= 12'd1000;
			tol_q <= 8'd30;
			db_q <= 15'd2621;
		end else begin
			state_q <= state_nx;
			if (state_q == T_DONE && out_free) begin
				res_valid_q <= 1'b1;
				if (touch_q) kept_q <= mask_q;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LEFT_CX: lcx_q <= cfg_wdata[11:0];
					CFG_LEFT_CY: lcy_q <= cfg_wdata[11:0];
					CFG_RIGHT_CX: rcx_q <= cfg_wdata[11:0];
					CFG_RIGHT_CY: rcy_q <= cfg_wdata[11:0];
					CFG_ZONE: zone_q <= cfg_wdata[11:0];
					CFG_TOL: tol_q <= cfg_wdata[7:0];
					CFG_DEADBAND: db_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end
endmodule

FILE: rtl/touch_gamepad_report_decoder.sv
// top level of the touch gamepad report decoder: front, queue and back part
// depends on tgrd_pkg, tgrd_if, tgrd_front, tgrd_queue, tgrd_back
//
// channel   dir  payload                                      accepted when
// in_ch     in   report_byte, last_byte                       valid && ready
// out_ch    out  roll, pitch, yaw, throttle_up/down, mask,    valid && ready
//                report_kind
// cfg       in   cfg_index, cfg_wdata                         cfg_we
//
// a byte that does not end a report is taken every cycle while the back part is idle
// a touch report decodes each contact in turn: four byte fetches, the tip check and, for a
// touching contact, up to ten button zone compares and, if no hit, two reciprocal divides
// a switch report reads its four bytes in turn, bound by the single buffer read port
// the two-entry queue takes up to two bytes while the back part decodes or the result waits
// reset clears the byte count, the kept buttons and the registers to their defaults
module touch_gamepad_report_decoder #(
	parameter int MAX_REPORT_BYTES = 32,
	parameter int NUM_CONTACTS = 4,
	parameter int NUM_BUTTON_ZONES = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tgrd_byte_if.sink                       in_ch,
	tgrd_result_if.source                   out_ch,
	input  logic                            cfg_we,
	input  logic [tgrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgrd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tgrd_pkg::*;

	logic        push_valid, push_ready, pop_valid, pop_ready;
	queue_item_t push_item, pop_item;
	result_t     res;

	tgrd_front #(.MAX_REPORT_BYTES(MAX_REPORT_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	tgrd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	tgrd_back #(
		.MAX_REPORT_BYTES(MAX_REPORT_BYTES),
		.NUM_CONTACTS    (NUM_CONTACTS),
		.NUM_BUTTON_ZONES(NUM_BUTTON_ZONES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item (pop_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.res_valid(out_ch.valid),
		.res_ready(out_ch.ready),
		.res      (res)
	);

	assign out_ch.roll = res.roll;
	assign out_ch.pitch = res.pitch;
	assign out_ch.yaw = res.yaw;
	assign out_ch.throttle_up = res.tup;
	assign out_ch.throttle_down = res.tdown;
	assign out_ch.button_mask = res.mask;
	assign out_ch.report_kind = res.kind;
endmodule

FILE: rtl/tgrd_checker.sv
// port-level checks of the decoder result channel, bound to the top level
// depends on touch_gamepad_report_decoder
module tgrd_assert (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] roll,
	input logic signed [15:0] pitch,
	input logic signed [15:0] yaw,
	input logic [14:0]        tup,
	input logic [14:0]        tdown,
	input logic               kind
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(roll) && $stable(pitch) && $stable(yaw)
			&& $stable(tup) && $stable(tdown) && $stable(kind))
		else $error("result changed while stalled");

	// deadband keeps the two throttle directions apart
	a_touch_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> tup == 15'd0 || tdown == 15'd0)
		else $error("both throttle directions set");

	// switch roll and yaw are whole steps of 256 and throttle is all or nothing
	a_switch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> roll[7:0] == 8'd0 && yaw[7:0] == 8'd0
			&& (tup == 15'd0 || tup == 15'h7fff) && (tdown == 15'd0 || tdown == 15'h7fff))
		else $error("bad switch layout result");
endmodule

bind touch_gamepad_report_decoder tgrd_assert u_tgrd_assert (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.roll     (out_ch.roll),
	.pitch    (out_ch.pitch),
	.yaw      (out_ch.yaw),
	.tup      (out_ch.throttle_up),
	.tdown    (out_ch.throttle_down),
	.kind     (out_ch.report_kind)
);
